// ===== rtl/core/cfpc_pkg.sv =====
// Package: shared types, constants and the CRC byte update for the frame checker.
`timescale 1ns / 1ps

package cfpc_pkg;

  // Default saturation limit of the byte counter
  localparam int unsigned CFPC_COUNT_LIMIT = 63;

  // Frame geometry
  localparam int unsigned MIN_BYTES     = 18;
  localparam int unsigned HDR_BYTES     = 16;
  localparam int unsigned LEN_SENSOR    = 41;
  localparam int unsigned LEN_HEARTBEAT = 28;
  localparam int unsigned LEN_FAULT     = 26;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC     = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_SENSOR    = 3'd2,
    CFG_HEARTBEAT = 3'd3,
    CFG_FAULT     = 3'd4
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_VER  = 3'd3,
    ST_BAD_TYPE = 3'd4,
    ST_BAD_CRC  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_SENSOR    = 2'd0,
    KIND_HEARTBEAT = 2'd1,
    KIND_FAULT     = 2'd2,
    KIND_UNKNOWN   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] magic_word;
    logic [7:0]  expected_version;
    logic [7:0]  sensor_type_code;
    logic [7:0]  heartbeat_type_code;
    logic [7:0]  fault_type_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    kind_e       msg_kind;
    logic [31:0] node_word;
    logic [31:0] sequence_word;
    logic [31:0] uptime_word;
  } out_item_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/cfpc_cfg_regs.sv =====
// Configuration registers of the frame checker.
`timescale 1ns / 1ps

module cfpc_cfg_regs
  import cfpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAGIC:     cfg_d.magic_word          = cfg_data_i;
        CFG_VERSION:   cfg_d.expected_version    = cfg_data_i[7:0];
        CFG_SENSOR:    cfg_d.sensor_type_code    = cfg_data_i[7:0];
        CFG_HEARTBEAT: cfg_d.heartbeat_type_code = cfg_data_i[7:0];
        CFG_FAULT:     cfg_d.fault_type_code     = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word          <= 16'h0000;
      cfg_q.expected_version    <= 8'h00;
      cfg_q.sensor_type_code    <= 8'h00;
      cfg_q.heartbeat_type_code <= 8'h01;
      cfg_q.fault_type_code     <= 8'h02;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/cfpc_parser.sv =====
// Input register, per-packet state and status evaluation of the frame checker.
`timescale 1ns / 1ps

module cfpc_parser
  import cfpc_pkg::*;
#(
  parameter int unsigned COUNT_LIMIT = CFPC_COUNT_LIMIT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o
);

  localparam int unsigned CntW = $clog2(COUNT_LIMIT + 1);

  // Input register
  logic     in_valid_q;
  in_item_t in_q;

  // Per-packet state
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    held0_q, held0_d, held1_q, held1_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]    magic_low_q, magic_low_d;
  logic [1:0]    marks_q, marks_d;
  kind_e         kind_q, kind_d;
  logic [31:0]   words_q [3];
  logic [31:0]   words_d [3];

  logic          advance;
  logic [1:0]    word_idx;
  logic [7:0]    b;
  logic [CntW-1:0] want;
  status_e       status;

  // A non-final byte always moves on; a final byte waits for the result slot
  assign advance    = in_valid_q && (!in_q.last_byte || res_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Header capture, delayed CRC and counter update for the held byte
  assign b        = in_q.data_byte;
  assign word_idx = cnt_q[3:2] - 2'd1;

  always_comb begin
    crc_d       = crc_q;
    magic_low_d = magic_low_q;
    marks_d     = marks_q;
    kind_d      = kind_q;
    words_d     = words_q;
    if (cnt_q == CntW'(0)) begin
      magic_low_d = b;
    end else if (cnt_q == CntW'(1)) begin
      if ({b, magic_low_q} != cfg_i.magic_word) marks_d[0] = 1'b1;
    end else if (cnt_q == CntW'(2)) begin
      if (b != cfg_i.expected_version) marks_d[1] = 1'b1;
    end else if (cnt_q == CntW'(3)) begin
      if (b == cfg_i.sensor_type_code)         kind_d = KIND_SENSOR;
      else if (b == cfg_i.heartbeat_type_code) kind_d = KIND_HEARTBEAT;
      else if (b == cfg_i.fault_type_code)     kind_d = KIND_FAULT;
      else                                     kind_d = KIND_UNKNOWN;
    end else if (cnt_q < CntW'(HDR_BYTES)) begin
      words_d[word_idx][{cnt_q[1:0], 3'b000} +: 8] = b;
    end
    if (cnt_q >= CntW'(2)) crc_d = crc_fold(crc_q, held0_q);
    held0_d = held1_q;
    held1_d = b;
    cnt_d   = (cnt_q < CntW'(COUNT_LIMIT)) ? cnt_q + CntW'(1) : cnt_q;
  end

  // Checks in priority order on the updated state
  always_comb begin
    unique case (kind_d)
      KIND_SENSOR:    want = CntW'(LEN_SENSOR);
      KIND_HEARTBEAT: want = CntW'(LEN_HEARTBEAT);
      default:        want = CntW'(LEN_FAULT);
    endcase
    if (cnt_d < CntW'(MIN_BYTES))     status = ST_BAD_LEN;
    else if (marks_d[0])              status = ST_BAD_MAGIC;
    else if (marks_d[1])              status = ST_BAD_VER;
    else if (kind_d == KIND_UNKNOWN)  status = ST_BAD_TYPE;
    else if (cnt_d != want)           status = ST_BAD_LEN;
    else if (crc_d != {held1_d, held0_d}) status = ST_BAD_CRC;
    else                              status = ST_OK;
  end

  assign res_valid_o         = in_valid_q && in_q.last_byte;
  assign res_o.status        = status;
  assign res_o.msg_kind      = kind_d;
  assign res_o.node_word     = (status == ST_OK) ? words_d[0] : 32'h0;
  assign res_o.sequence_word = (status == ST_OK) ? words_d[1] : 32'h0;
  assign res_o.uptime_word   = (status == ST_OK) ? words_d[2] : 32'h0;

  // Advance the packet state; clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      held0_q     <= 8'h00;
      held1_q     <= 8'h00;
      cnt_q       <= '0;
      magic_low_q <= 8'h00;
      marks_q     <= 2'b00;
      kind_q      <= KIND_UNKNOWN;
      words_q     <= '{default: 32'h0};
    end else if (advance) begin
      if (in_q.last_byte) begin
        crc_q       <= CRC_INIT;
        held0_q     <= 8'h00;
        held1_q     <= 8'h00;
        cnt_q       <= '0;
        magic_low_q <= 8'h00;
        marks_q     <= 2'b00;
        kind_q      <= KIND_UNKNOWN;
        words_q     <= '{default: 32'h0};
      end else begin
        crc_q       <= crc_d;
        held0_q     <= held0_d;
        held1_q     <= held1_d;
        cnt_q       <= cnt_d;
        magic_low_q <= magic_low_d;
        marks_q     <= marks_d;
        kind_q      <= kind_d;
        words_q     <= words_d;
      end
    end
  end

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(COUNT_LIMIT))
    else $error("byte counter beyond its limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last_byte |=> cnt_q == '0 && crc_q == CRC_INIT && kind_q == KIND_UNKNOWN)
    else $error("packet state not cleared after final byte");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.last_byte |=> cnt_q != '0)
    else $error("byte counter did not advance");

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_OK |-> res_o.msg_kind != KIND_UNKNOWN)
    else $error("good packet reported with unknown kind");

endmodule

// ===== rtl/core/cfpc_out_reg.sv =====
// Result register of the frame checker.
`timescale 1ns / 1ps

module cfpc_out_reg
  import cfpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  output logic      res_ready_o,
  input  out_item_t res_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      out_valid_q;
  out_item_t out_q;

  // Take a new result when empty or when the held one leaves this cycle
  assign res_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/crc_framed_packet_checker.sv =====
// Top level: byte-stream frame checker with CRC-16/CCITT-FALSE trailer.
//
//   Port group  Direction  Handshake               Transfer content
//   in_*        input      in_valid_i/in_ready_o   one packet byte and last-byte flag
//   out_*       output     out_valid_o/out_ready_i one status item per packet
//   cfg_*       input      cfg_we_i                register index and write data
//
// One byte per cycle: a byte is held in the input register, where the delayed CRC
// byte update and header capture for it are done. A final byte's status is
// registered in the result register and appears in the cycle after it is processed.
// Reset clears control and packet state and loads the register defaults.
// A stalled output only holds a final byte; other bytes keep flowing.
`timescale 1ns / 1ps

module crc_framed_packet_checker
  import cfpc_pkg::*;
#(
  parameter int unsigned COUNT_LIMIT = CFPC_COUNT_LIMIT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  cfpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cfpc_parser #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  cfpc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
